@@ rtl/core/rbsi_pkg.sv @@
// shared types and constants for the ray versus box slab intersection unit
// no dependencies

package rbsi_pkg;

   localparam int CoordWidth = 32;
   localparam int FracBits   = 16;
   localparam int TolWidth   = 16;
   localparam int NumAxes    = 3;
   localparam int ReqBits    = 12 * CoordWidth;
   localparam int RspBits    = 2 * CoordWidth;
   localparam int FifoDepth  = 4;
   localparam int FifoAw     = 2;
   // numerator magnitude (diff fits coord+1 bits) shifted up by fraction bits
   localparam int NumWidth   = CoordWidth + 1 + FracBits;
   localparam int DivSteps   = NumWidth;

   localparam logic [TolWidth-1:0] TolReset = TolWidth'(6);
   localparam logic signed [CoordWidth-1:0] CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
   localparam logic signed [CoordWidth-1:0] CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};

   // per-axis classification from the front part
   typedef struct packed {
      logic                  parallel;
      logic                  enclosed;
      logic                  neg_a;
      logic                  neg_b;
      logic [CoordWidth:0]   num_a;
      logic [CoordWidth:0]   num_b;
      logic [CoordWidth-1:0] den;
   } axis_type;

   typedef struct packed {
      axis_type [NumAxes-1:0] axis;
   } job_type;

endpackage

@@ rtl/core/rbsi_front.sv @@
// front part: unpacks a request and classifies each axis (parallel test, operand magnitudes)
// depends on rbsi_pkg

module rbsi_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [rbsi_pkg::ReqBits-1:0]      in_data,
   input  logic [rbsi_pkg::TolWidth-1:0]     tolerance,
   output logic                              out_valid,
   input  logic                              out_ready,
   output rbsi_pkg::job_type                 out_job
);
   import rbsi_pkg::*;

   logic    valid_ff;
   job_type job_ff, job_in;

   // classify all three axes
   always_comb begin
      logic signed [CoordWidth-1:0] org, dir, ca, cb;
      logic [CoordWidth-1:0]        mag;
      logic signed [CoordWidth:0]   da, db;
      for (int ax = 0; ax < NumAxes; ax++) begin
         org = in_data[ax*CoordWidth +: CoordWidth];
         dir = in_data[(3+ax)*CoordWidth +: CoordWidth];
         ca  = in_data[(6+ax)*CoordWidth +: CoordWidth];
         cb  = in_data[(9+ax)*CoordWidth +: CoordWidth];
         mag = dir[CoordWidth-1] ? (~dir + 1'b1) : dir;
         da  = {ca[CoordWidth-1], ca} - {org[CoordWidth-1], org};
         db  = {cb[CoordWidth-1], cb} - {org[CoordWidth-1], org};
         job_in.axis[ax].parallel = mag <= {{(CoordWidth-TolWidth){1'b0}}, tolerance};
         job_in.axis[ax].enclosed = (ca <= org && org <= cb) || (cb <= org && org <= ca);
         job_in.axis[ax].neg_a    = da[CoordWidth] ^ dir[CoordWidth-1];
         job_in.axis[ax].neg_b    = db[CoordWidth] ^ dir[CoordWidth-1];
         job_in.axis[ax].num_a    = da[CoordWidth] ? (~da + 1'b1) : da;
         job_in.axis[ax].num_b    = db[CoordWidth] ? (~db + 1'b1) : db;
         job_in.axis[ax].den      = mag;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         job_ff <= job_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_job   = job_ff;
endmodule

@@ rtl/core/rbsi_fifo.sv @@
// short queue between front and back parts, register based
// depends on rbsi_pkg

module rbsi_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rbsi_pkg::job_type  in_job,
   output logic               out_valid,
   input  logic               out_ready,
   output rbsi_pkg::job_type  out_job
);
   import rbsi_pkg::*;

   job_type              mem_ff [FifoDepth];
   logic [FifoAw-1:0]    wr_ff, rd_ff;
   logic [FifoAw:0]      cnt_ff;
   logic                 push, pop;

   assign in_ready  = cnt_ff != FifoAw'(0) + (FifoAw+1)'(FifoDepth);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_job   = mem_ff[rd_ff];

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (FifoAw+1)'(push) - (FifoAw+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= in_job;
   end
endmodule

@@ rtl/core/rbsi_back.sv @@
// back part: pipelined restoring dividers (one quotient bit per stage) and slab combine
// depends on rbsi_pkg

module rbsi_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  rbsi_pkg::job_type             in_job,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          out_hit,
   output logic [rbsi_pkg::RspBits-1:0]  out_data
);
   import rbsi_pkg::*;

   localparam int Nq = 2 * NumAxes;  // two quotients per axis
   localparam int Dw = CoordWidth;
   localparam int Nw = NumWidth;

   // per-stage divider state
   typedef struct packed {
      logic [Nw-1:0]  num;   // numerator bits still to shift in, msb first
      logic [Nw-1:0]  quo;
      logic [Dw:0]    rem;
      logic [Dw-1:0]  den;
      logic           neg;
   } div_type;

   typedef struct packed {
      logic [NumAxes-1:0] parallel;
      logic [NumAxes-1:0] enclosed;
   } side_type;

   logic                    adv;
   div_type  [Nq-1:0]       load_in;
   side_type                side_in;
   logic     [DivSteps-1:0] v_ff;
   div_type  [Nq-1:0]       d_ff [DivSteps];
   side_type                s_ff [DivSteps];

   // combine stage registers
   logic                  cv_ff;
   logic signed [Dw-1:0]  q_ff [Nq];
   side_type              cs_ff;
   logic                  ov_ff;
   logic                  hit_ff;
   logic [RspBits-1:0]    data_ff;

   // whole pipeline moves together, output register frees it
   assign adv      = !ov_ff || out_ready;
   assign in_ready = adv;

   // stage 0 load
   always_comb begin
      for (int k = 0; k < Nq; k++) begin
         load_in[k].num = (k % 2 == 0) ? {in_job.axis[k/2].num_a, {FracBits{1'b0}}}
                                       : {in_job.axis[k/2].num_b, {FracBits{1'b0}}};
         load_in[k].neg = (k % 2 == 0) ? in_job.axis[k/2].neg_a : in_job.axis[k/2].neg_b;
         // a parallel axis may have zero divisor; any value is ignored then
         load_in[k].den = in_job.axis[k/2].den;
         load_in[k].quo = '0;
         load_in[k].rem = '0;
      end
      for (int ax = 0; ax < NumAxes; ax++) begin
         side_in.parallel[ax] = in_job.axis[ax].parallel;
         side_in.enclosed[ax] = in_job.axis[ax].enclosed;
      end
   end

   // divider stages
   for (genvar s = 0; s < DivSteps; s++) begin : g_div
      logic             cur_v;
      div_type [Nq-1:0] cur, nx_in;
      side_type         cur_s;
      if (s == 0) begin : g_first
         assign cur_v = in_valid;
         assign cur   = load_in;
         assign cur_s = side_in;
      end else begin : g_next
         assign cur_v = v_ff[s-1];
         assign cur   = d_ff[s-1];
         assign cur_s = s_ff[s-1];
      end
      always_comb begin
         logic [Dw:0] r2;
         for (int k = 0; k < Nq; k++) begin
            r2 = {cur[k].rem[Dw-1:0], cur[k].num[Nw-1]};
            nx_in[k] = cur[k];
            nx_in[k].num = {cur[k].num[Nw-2:0], 1'b0};
            if (r2 >= {1'b0, cur[k].den}) begin
               nx_in[k].rem = r2 - {1'b0, cur[k].den};
               nx_in[k].quo = {cur[k].quo[Nw-2:0], 1'b1};
            end else begin
               nx_in[k].rem = r2;
               nx_in[k].quo = {cur[k].quo[Nw-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= cur_v;
         end
         if (adv) begin
            d_ff[s] <= nx_in;
            s_ff[s] <= cur_s;
         end
      end
   end

   // saturate and sign each quotient
   logic signed [Dw-1:0] q_in [Nq];
   always_comb begin
      logic [Nw-1:0] q;
      for (int k = 0; k < Nq; k++) begin
         q = d_ff[DivSteps-1][k].quo;
         if (d_ff[DivSteps-1][k].neg) begin
            if (q >= Nw'({1'b1, {(Dw-1){1'b0}}})) q_in[k] = CoordMin;
            else q_in[k] = -$signed(q[Dw-1:0]);
         end else begin
            if (q > Nw'({1'b0, {(Dw-1){1'b1}}})) q_in[k] = CoordMax;
            else q_in[k] = $signed(q[Dw-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= 1'b0;
      end else if (adv) begin
         cv_ff <= v_ff[DivSteps-1];
      end
      if (adv) begin
         for (int k = 0; k < Nq; k++) q_ff[k] <= q_in[k];
         cs_ff <= s_ff[DivSteps-1];
      end
   end

   // slab combine over x, y, z
   logic              hit_in;
   logic signed [Dw-1:0] tn, tf;
   always_comb begin
      logic signed [Dw-1:0] lo, hi;
      tn = CoordMin;
      tf = CoordMax;
      hit_in = 1'b1;
      for (int ax = 0; ax < NumAxes; ax++) begin
         lo = (q_ff[2*ax] > q_ff[2*ax+1]) ? q_ff[2*ax+1] : q_ff[2*ax];
         hi = (q_ff[2*ax] > q_ff[2*ax+1]) ? q_ff[2*ax] : q_ff[2*ax+1];
         if (hit_in) begin
            if (cs_ff.parallel[ax]) begin
               if (!cs_ff.enclosed[ax]) hit_in = 1'b0;
            end else begin
               if (lo > tn) tn = lo;
               if (hi < tf) tf = hi;
               if (tn > tf || tf < 0) hit_in = 1'b0;
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= cv_ff;
      end
      if (adv) begin
         hit_ff  <= hit_in;
         data_ff <= hit_in ? {tf, tn} : '0;
      end
   end

   assign out_valid = ov_ff;
   assign out_hit   = hit_ff;
   assign out_data  = data_ff;
endmodule

@@ rtl/core/ray_box_slab_intersect_unit.sv @@
// ray versus axis-aligned box, slab method, signed Q16.16
// pipeline: 1 front register, queue, 49 divider stages, 2 more registers (quotients, output)
// throughput: one item per cycle while rsp_tready is high, set by the fully pipelined quotient stages
// reset: synchronous active high, clears all valids; tolerance returns to 6
// depends on rbsi_pkg, rbsi_front, rbsi_fifo, rbsi_back

module ray_box_slab_intersect_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_x,y,z, direction_x,y,z, corner_a_x,y,z, corner_b_x,y,z (lsb first)
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // entry_distance, exit_distance (lsb first)
   output logic [63:0]  rsp_tdata,
   // hit
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);
   import rbsi_pkg::*;

   logic [TolWidth-1:0] tol_ff;
   logic                f_valid, f_ready, q_valid, q_ready;
   job_type             f_job, q_job;

   // tolerance register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TolReset;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   rbsi_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(req_tdata),
      .tolerance(tol_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_job(f_job)
   );

   rbsi_fifo u_fifo (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
   );

   rbsi_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_job(q_job),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_hit(rsp_tuser), .out_data(rsp_tdata)
   );
endmodule
